>>> sv/prps_pkg.sv
// prps_pkg: types, constants and constant-divide helpers for the progress ring pixel shader
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
package prps_pkg;

  localparam int FRAME_COLS = 1024;
  localparam int FRAME_ROWS = 768;

  localparam logic [2:0] REG_CENTER_X  = 3'd0;
  localparam logic [2:0] REG_CENTER_Y  = 3'd1;
  localparam logic [2:0] REG_RADIUS    = 3'd2;
  localparam logic [2:0] REG_THICKNESS = 3'd3;
  localparam logic [2:0] REG_START_COL = 3'd4;
  localparam logic [2:0] REG_END_COL   = 3'd5;
  localparam logic [2:0] REG_PROGRESS  = 3'd6;
  localparam logic [2:0] REG_GLOW      = 3'd7;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] bg_pixel;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        pixel_written;
  } out_t;

  typedef struct packed {
    logic [11:0] ctr_col;
    logic [11:0] ctr_row;
    logic [9:0]  ring_radius;
    logic [5:0]  ring_thickness;
    logic [23:0] start_color;
    logic [23:0] end_color;
    logic [8:0]  progress_degrees;
    logic [6:0]  glow_level;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        off;
    logic [31:0] bg;
    logic [12:0] radial;
    logic [8:0]  angle;
  } geom_t;

  // floor(v / 360) for v below 92160
  function automatic logic [7:0] div360(input logic [16:0] v);
    logic [33:0] p;
    p = 34'(v) * 34'(93207);
    return p[32:25];
  endfunction

  // floor(v / 255) for v below 65280
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [32:0] p;
    p = 33'(v) * 33'(65794);
    return p[31:24];
  endfunction

  // floor(v / 100) for v below 2^16
  function automatic logic [9:0] div100(input logic [15:0] v);
    logic [33:0] p;
    p = 34'(v) * 34'(167773);
    return p[33:24];
  endfunction

endpackage

>>> sv/progress_ring_pixel_shader.sv
// progress_ring_pixel_shader: top level, configuration registers and the two pipeline halves
// depends on prps_pkg, prps_geom, prps_shade
`timescale 1ns / 1ps
// usage
//   a pixel request is taken on any clock edge with start high; busy is always low,
//   so one pixel can enter every cycle
//   in_data carries pixel_x, pixel_y and the background pixel
//   the shaded pixel shows on out_data with out_valid high for one cycle,
//   in request order
//   throughput is one pixel per clock; the root and angle divider run as a
//   seven stage pipeline, up to two root steps and one quotient bit per stage
//   the receiver cannot stall, so results are never held back
//   configuration: cfg_we writes cfg_data to register cfg_index on the same edge;
//   write only while no pixel is in flight
//   reset (rst_n low, synchronous) empties the pipeline and loads the default
//   ring settings
module progress_ring_pixel_shader (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  prps_pkg::in_t   in_data,
  output logic            out_valid,
  output prps_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [23:0]     cfg_data
);
  import prps_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  geom_t geom;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:  cfg_nxt.ctr_col          = cfg_data[11:0];
        REG_CENTER_Y:  cfg_nxt.ctr_row          = cfg_data[11:0];
        REG_RADIUS:    cfg_nxt.ring_radius      = cfg_data[9:0];
        REG_THICKNESS: cfg_nxt.ring_thickness   = cfg_data[5:0];
        REG_START_COL: cfg_nxt.start_color      = cfg_data;
        REG_END_COL:   cfg_nxt.end_color        = cfg_data;
        REG_PROGRESS:  cfg_nxt.progress_degrees = cfg_data[8:0];
        REG_GLOW:      cfg_nxt.glow_level       = cfg_data[6:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctr_col          <= 12'd512;
      cfg_r.ctr_row          <= 12'd384;
      cfg_r.ring_radius      <= 10'd40;
      cfg_r.ring_thickness   <= 6'd3;
      cfg_r.start_color      <= 24'd0;
      cfg_r.end_color        <= 24'd0;
      cfg_r.progress_degrees <= 9'd0;
      cfg_r.glow_level       <= 7'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy = 1'b0;

  prps_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .geom_out (geom)
  );

  prps_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom_in   (geom),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sv/prps_geom.sv
// prps_geom: offset, squared distance, pipelined integer square root and angle divider
// depends on prps_pkg
`timescale 1ns / 1ps
module prps_geom (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  prps_pkg::in_t  in_data,
  input  prps_pkg::cfg_t cfg,
  output prps_pkg::geom_t geom_out
);
  import prps_pkg::*;

  localparam int NSTG = 7;

  typedef struct packed {
    logic        off;
    logic [31:0] bg;
    logic [25:0] n;
    logic [25:0] r;
    logic [18:0] rem;
    logic [6:0]  q;
    logic [12:0] den;
    logic [8:0]  base;
  } it_t;

  logic        v1_r, v1_nxt;
  logic        off1_r, off1_nxt;
  logic [31:0] bg1_r;
  logic [11:0] adx1_r, ady1_r, adx_nxt, ady_nxt;
  logic        dxn1_r, dyn1_r, dxn_nxt, dyn_nxt;

  it_t            stg0_nxt;
  it_t            pipe_r [0:NSTG];
  it_t            pipe_nxt [0:NSTG];
  logic [NSTG:0]  vld_r;

  always_comb begin
    logic [12:0] dx, dy;
    dx = {1'b0, in_data.pixel_x} - {1'b0, cfg.ctr_col};
    dy = {1'b0, in_data.pixel_y} - {1'b0, cfg.ctr_row};
    dxn_nxt = dx[12];
    dyn_nxt = dy[12];
    adx_nxt = dx[12] ? 12'(-dx) : dx[11:0];
    ady_nxt = dy[12] ? 12'(-dy) : dy[11:0];
    off1_nxt = ({1'b0, in_data.pixel_x} >= 13'(FRAME_COLS)) ||
               ({1'b0, in_data.pixel_y} >= 13'(FRAME_ROWS));
    v1_nxt = in_valid;
  end

  always_comb begin
    logic [11:0] sel;
    logic [23:0] sx, sy;
    sx = 24'(adx1_r) * 24'(adx1_r);
    sy = 24'(ady1_r) * 24'(ady1_r);
    sel = (dxn1_r ^ dyn1_r) ? adx1_r : ady1_r;
    stg0_nxt.off = off1_r;
    stg0_nxt.bg  = bg1_r;
    stg0_nxt.n   = 26'(sx) + 26'(sy);
    stg0_nxt.r   = '0;
    stg0_nxt.rem = 19'(sel) * 19'(90);
    stg0_nxt.q   = '0;
    stg0_nxt.den = 13'(adx1_r) + 13'(ady1_r) + 13'd1;
    case ({dxn1_r, dyn1_r})
      2'b00:   stg0_nxt.base = 9'd0;
      2'b10:   stg0_nxt.base = 9'd90;
      2'b11:   stg0_nxt.base = 9'd180;
      default: stg0_nxt.base = 9'd270;
    endcase
  end

  // up to two root iterations and one quotient bit per stage
  always_comb begin
    it_t         cur;
    logic [25:0] bv;
    logic [19:0] dsh;
    pipe_nxt[0] = stg0_nxt;
    for (int j = 0; j < NSTG; j++) begin
      cur = pipe_r[j];
      for (int k = 0; k < 2; k++) begin
        if (2 * j + k < 13) begin
          bv = 26'd1 << (24 - 2 * (2 * j + k));
          if (cur.n >= cur.r + bv) begin
            cur.n = cur.n - (cur.r + bv);
            cur.r = (cur.r >> 1) + bv;
          end else begin
            cur.r = cur.r >> 1;
          end
        end
      end
      dsh = {7'd0, cur.den} << (6 - j);
      if ({1'b0, cur.rem} >= dsh) begin
        cur.rem = cur.rem - dsh[18:0];
        cur.q[6 - j] = 1'b1;
      end
      pipe_nxt[j + 1] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= '0;
    end else begin
      v1_r  <= v1_nxt;
      vld_r <= {vld_r[NSTG-1:0], v1_r};
    end
    off1_r <= off1_nxt;
    bg1_r  <= in_data.bg_pixel;
    adx1_r <= adx_nxt;
    ady1_r <= ady_nxt;
    dxn1_r <= dxn_nxt;
    dyn1_r <= dyn_nxt;
    for (int j = 0; j <= NSTG; j++) begin
      pipe_r[j] <= pipe_nxt[j];
    end
  end

  assign geom_out.valid  = vld_r[NSTG];
  assign geom_out.off    = pipe_r[NSTG].off;
  assign geom_out.bg     = pipe_r[NSTG].bg;
  assign geom_out.radial = pipe_r[NSTG].r[12:0];
  assign geom_out.angle  = pipe_r[NSTG].base + {2'b00, pipe_r[NSTG].q};

endmodule

>>> sv/prps_shade.sv
// prps_shade: band and halo test, alpha, angle color mix and blend over the background
// depends on prps_pkg
`timescale 1ns / 1ps
module prps_shade (
  input  logic            clk,
  input  logic            rst_n,
  input  prps_pkg::geom_t geom_in,
  input  prps_pkg::cfg_t  cfg,
  output logic            out_valid,
  output prps_pkg::out_t  out_data
);
  import prps_pkg::*;

  // stage c
  logic        vc_r, passc_r, inbc_r, haloc_r;
  logic [31:0] bgc_r;
  logic [16:0] mixc_r [0:2];
  logic [15:0] boostc_r;
  logic [7:0]  abasec_r;
  logic [10:0] ganumc_r;
  logic        passc_nxt, inbc_nxt, haloc_nxt;
  logic [16:0] mixc_nxt [0:2];
  logic [15:0] boostc_nxt;
  logic [7:0]  abasec_nxt;
  logic [10:0] ganumc_nxt;

  // stage d
  logic        vd_r, wrd_r;
  logic [31:0] bgd_r;
  logic [23:0] cold_r, cold_nxt;
  logic [7:0]  alphad_r, alphad_nxt;
  logic        wrd_nxt;

  // stage e
  logic        ve_r, wre_r;
  logic [31:0] bge_r;
  logic [23:0] cole_r;
  logic [7:0]  alphae_r;
  logic [15:0] prode_r [0:2];
  logic [15:0] prode_nxt [0:2];

  // output
  logic        vo_r;
  out_t        out_r, out_nxt;

  always_comb begin
    logic [4:0]  h;
    logic [9:0]  inner;
    logic [10:0] outer;
    logic [12:0] d;
    logic [3:0]  hoff;
    logic [8:0]  t;
    h = cfg.ring_thickness[5:1];
    inner = (cfg.ring_radius > 10'(h)) ? cfg.ring_radius - 10'(h) : 10'd0;
    outer = {1'b0, cfg.ring_radius} + 11'(h);
    d = (geom_in.radial >= 13'(cfg.ring_radius)) ? geom_in.radial - 13'(cfg.ring_radius)
                                                 : 13'(cfg.ring_radius) - geom_in.radial;
    passc_nxt = geom_in.off || (geom_in.angle > cfg.progress_degrees);
    inbc_nxt = (geom_in.radial >= 13'(inner)) && (geom_in.radial <= 13'(outer));
    haloc_nxt = (cfg.glow_level != 7'd0) && (geom_in.radial > 13'(outer)) &&
                (geom_in.radial < 13'(outer) + 13'd8);
    if (d >= 13'(h))              abasec_nxt = 8'd0;
    else if (d + 13'd1 == 13'(h)) abasec_nxt = 8'd128;
    else                          abasec_nxt = 8'd255;
    hoff = 4'(geom_in.radial - 13'(outer));
    ganumc_nxt = 11'(cfg.glow_level) * 11'(4'd8 - hoff);
    boostc_nxt = 16'(abasec_nxt) * (16'd100 + 16'(cfg.glow_level));
    t = inbc_nxt ? geom_in.angle : 9'd180;
    for (int c = 0; c < 3; c++) begin
      mixc_nxt[c] = 17'(cfg.start_color[8*c +: 8]) * 17'(9'd360 - t) +
                    17'(cfg.end_color[8*c +: 8]) * 17'(t);
    end
  end

  always_comb begin
    logic [9:0] q100;
    logic [7:0] ab;
    logic [6:0] ga;
    for (int c = 0; c < 3; c++) begin
      cold_nxt[8*c +: 8] = div360(mixc_r[c]);
    end
    q100 = div100(boostc_r);
    if (cfg.glow_level != 7'd0) ab = (q100 > 10'd255) ? 8'd255 : q100[7:0];
    else                        ab = abasec_r;
    ga = ganumc_r[10:4];
    alphad_nxt = inbc_r ? ab : {1'b0, ga};
    wrd_nxt = !passc_r && (inbc_r || (haloc_r && ga != 7'd0));
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prode_nxt[c] = 16'(cold_r[8*c +: 8]) * 16'(alphad_r) +
                     16'(bgd_r[8*c +: 8]) * 16'(8'd255 - alphad_r);
    end
  end

  always_comb begin
    logic [23:0] mixd;
    for (int c = 0; c < 3; c++) begin
      mixd[8*c +: 8] = div255(prode_r[c]);
    end
    out_nxt.pixel_written = wre_r;
    if (!wre_r)                 out_nxt.pixel_out = bge_r;
    else if (alphae_r == 8'd255) out_nxt.pixel_out = {8'h00, cole_r};
    else if (alphae_r == 8'd0)   out_nxt.pixel_out = bge_r;
    else                        out_nxt.pixel_out = {8'h00, mixd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vc_r <= geom_in.valid;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vo_r <= ve_r;
    end
    passc_r  <= passc_nxt;
    inbc_r   <= inbc_nxt;
    haloc_r  <= haloc_nxt;
    bgc_r    <= geom_in.bg;
    boostc_r <= boostc_nxt;
    abasec_r <= abasec_nxt;
    ganumc_r <= ganumc_nxt;
    for (int c = 0; c < 3; c++) begin
      mixc_r[c]  <= mixc_nxt[c];
      prode_r[c] <= prode_nxt[c];
    end
    bgd_r    <= bgc_r;
    cold_r   <= cold_nxt;
    alphad_r <= alphad_nxt;
    wrd_r    <= wrd_nxt;
    bge_r    <= bgd_r;
    cole_r   <= cold_r;
    alphae_r <= alphad_r;
    wre_r    <= wrd_r;
    out_r    <= out_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for progress_ring_pixel_shader
// drives pixel requests and register writes, predicts each shaded pixel and compares in order
// depends on prps_pkg and the progress_ring_pixel_shader rtl
`timescale 1ns / 1ps
module tb_top;
  import prps_pkg::*;

  localparam int LATENCY = 13;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_CENTER_X;
  logic [23:0] cfg_data = '0;

  progress_ring_pixel_shader dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of the ring settings
  logic [11:0] sh_cx, sh_cy;
  logic [9:0] sh_radius;
  logic [5:0] sh_thick;
  logic [23:0] sh_start_col, sh_end_col;
  logic [8:0] sh_progress;
  logic [6:0] sh_glow;

  in_t pixel_queue[$];
  out_t shaded_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit cfg_pending = 0;
  logic [2:0] cfg_pend_idx;
  logic [23:0] cfg_pend_val;

  function automatic int unsigned floor_root(int unsigned n);
    int unsigned r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] angle_color(int unsigned t);
    logic [23:0] res;
    int unsigned a, b;
    res = '0;
    for (int s = 16; s >= 0; s -= 8) begin
      a = (sh_start_col >> s) & 8'hFF;
      b = (sh_end_col >> s) & 8'hFF;
      res[s+:8] = 8'((a * (360 - t) + b * t) / 360);
    end
    return res;
  endfunction

  function automatic logic [31:0] alpha_mix(logic [23:0] col, logic [31:0] bg,
                                            int unsigned al);
    logic [31:0] res;
    int unsigned a, b;
    if (al >= 255) return {8'h00, col};
    if (al == 0) return bg;
    res = '0;
    for (int s = 16; s >= 0; s -= 8) begin
      a = col[s+:8];
      b = bg[s+:8];
      res[s+:8] = 8'((a * al + b * (255 - al)) / 255);
    end
    return res;
  endfunction

  function automatic out_t shade_pixel(in_t p);
    out_t o;
    int h, inner, outer, dx, dy, adx, ady, den, ang, d, k;
    int unsigned rlen, al, ga;
    o.pixel_out = p.bg_pixel;
    o.pixel_written = 1'b0;
    h = sh_thick / 2;
    inner = (sh_radius > h) ? sh_radius - h : 0;
    outer = sh_radius + h;
    if (p.pixel_x >= FRAME_COLS || p.pixel_y >= FRAME_ROWS) return o;
    dx = int'(p.pixel_x) - int'(sh_cx);
    dy = int'(p.pixel_y) - int'(sh_cy);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    rlen = floor_root(adx * adx + ady * ady);
    den = adx + ady + 1;
    if (dx >= 0 && dy >= 0) ang = (ady * 90) / den;
    else if (dx < 0 && dy >= 0) ang = 90 + (adx * 90) / den;
    else if (dx < 0) ang = 180 + (ady * 90) / den;
    else ang = 270 + (adx * 90) / den;
    if (ang > int'(sh_progress)) return o;
    if (int'(rlen) >= inner && int'(rlen) <= outer) begin
      d = int'(rlen) - int'(sh_radius);
      if (d < 0) d = -d;
      al = 255;
      if (d > h - 2) begin
        k = d - h + 2;
        al = (k >= 2) ? 0 : 128;
      end
      if (sh_glow > 0) begin
        al = (al * (100 + sh_glow)) / 100;
        if (al > 255) al = 255;
      end
      o.pixel_out = alpha_mix(angle_color(ang), p.bg_pixel, al);
      o.pixel_written = 1'b1;
    end else if (sh_glow > 0 && int'(rlen) > outer && int'(rlen) < outer + 8) begin
      ga = (sh_glow * (8 - (int'(rlen) - outer))) / 16;
      if (ga > 0) begin
        o.pixel_out = alpha_mix(angle_color(180), p.bg_pixel, ga);
        o.pixel_written = 1'b1;
      end
    end
    return o;
  endfunction

  // driver: one request per accepted edge, with a random gap between requests
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      shaded_queue.push_back(shade_pixel(in_data));
      void'(pixel_queue.pop_front());
    end
    if (cfg_pending) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_pend_idx;
      cfg_data <= cfg_pend_val;
      cfg_pending = 0;
    end else begin
      cfg_we <= 1'b0;
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
      if (pixel_queue.size() > 0 && gap_left == 0) begin
        in_data <= pixel_queue[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left--;
      else if (pixel_queue.size() > 0) begin
        in_data <= pixel_queue[0];
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n && out_valid) begin
      if (shaded_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_o = shaded_queue.pop_front();
        if (out_data.pixel_out !== exp_o.pixel_out ||
            out_data.pixel_written !== exp_o.pixel_written) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b got %h/%b", exp_o.pixel_out,
                     exp_o.pixel_written, out_data.pixel_out, out_data.pixel_written);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n && !((start && !busy) || out_valid || cfg_we)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_pend_idx = idx;
    cfg_pend_val = val;
    cfg_pending = 1;
    @(posedge clk);
    case (idx)
      REG_CENTER_X: sh_cx = val[11:0];
      REG_CENTER_Y: sh_cy = val[11:0];
      REG_RADIUS: sh_radius = val[9:0];
      REG_THICKNESS: sh_thick = val[5:0];
      REG_START_COL: sh_start_col = val;
      REG_END_COL: sh_end_col = val;
      REG_PROGRESS: sh_progress = val[8:0];
      REG_GLOW: sh_glow = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || shaded_queue.size() > 0 || start) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic setup_ring(int unsigned cx, int unsigned cy, int unsigned rad,
                            int unsigned th, int unsigned sc, int unsigned ec,
                            int unsigned prog, int unsigned glow);
    write_reg(REG_CENTER_X, 24'(cx));
    write_reg(REG_CENTER_Y, 24'(cy));
    write_reg(REG_RADIUS, 24'(rad));
    write_reg(REG_THICKNESS, 24'(th));
    write_reg(REG_START_COL, 24'(sc));
    write_reg(REG_END_COL, 24'(ec));
    write_reg(REG_PROGRESS, 24'(prog));
    write_reg(REG_GLOW, 24'(glow));
  endtask

  function automatic in_t near_pixel(int span);
    in_t p;
    int ang_r, r, x, y;
    r = int'(sh_radius) + $urandom_range(0, 2 * span) - span;
    if (r < 0) r = 0;
    x = int'(sh_cx) + $urandom_range(0, 2 * r) - r;
    y = int'(sh_cy) + (($urandom_range(0, 1) == 1) ? 1 : -1) *
        int'(floor_root((r * r > (x - int'(sh_cx)) ** 2) ?
                        r * r - (x - int'(sh_cx)) ** 2 : 0));
    ang_r = $urandom_range(0, 7);
    if (ang_r == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end
    p.pixel_x = 12'(x);
    p.pixel_y = 12'(y);
    p.bg_pixel = $urandom();
    return p;
  endfunction

  initial begin
    in_t p;
    int unsigned th;
    sh_cx = 512; sh_cy = 384; sh_radius = 40; sh_thick = 3;
    sh_start_col = 0; sh_end_col = 0; sh_progress = 0; sh_glow = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full ring with glow at the reset center, corners and off screen
    setup_ring(512, 384, 40, 8, 24'hFF0000, 24'h0000FF, 360, 100);
    for (int i = 0; i < 8; i++) begin
      p.pixel_x = 12'(512 + (i % 3 - 1) * 40);
      p.pixel_y = 12'(384 + (i / 3 - 1) * 40);
      p.bg_pixel = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
      pixel_queue.push_back(p);
    end
    for (int r = 36; r <= 52; r++) begin
      p.pixel_x = 12'(512 + r); p.pixel_y = 12'(384); p.bg_pixel = 32'hA5A5_5A5A;
      pixel_queue.push_back(p);
    end
    p.pixel_x = 12'hFFF; p.pixel_y = 12'd0; pixel_queue.push_back(p);
    p.pixel_x = 12'd0; p.pixel_y = 12'hFFF; pixel_queue.push_back(p);
    p.pixel_x = 12'd1023; p.pixel_y = 12'd767; pixel_queue.push_back(p);
    drain();
    setup_ring(0, 0, 0, 1, 24'hFFFFFF, 24'h000000, 0, 0);
    p.pixel_x = 12'd0; p.pixel_y = 12'd0; p.bg_pixel = 32'h1234_5678; pixel_queue.push_back(p);
    p.pixel_x = 12'd1; pixel_queue.push_back(p);
    drain();
    setup_ring(4095, 4095, 1023, 63, 24'h00FF00, 24'hFFFFFF, 511, 127);
    for (int i = 0; i < 4; i++) pixel_queue.push_back(near_pixel(40));
    drain();

    // random phases
    for (int ph = 0; ph < 20; ph++) begin
      th = $urandom_range(0, 63);
      setup_ring($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 1023),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 767),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 200),
                 th, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                 $urandom_range(0, 4) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 360),
                 $urandom_range(0, 4) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 100));
      for (int i = 0; i < 100; i++) pixel_queue.push_back(near_pixel(int'(th) / 2 + 10));
      drain();
    end

    if (mismatches == 0 && !timed_out) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
